[hdl/aosa_pkg.sv]
// Package for the ADC owned-sample averager.
// Holds the payload word types, field widths and poll status codes.
// No dependencies; used by the core and the divider.
package aosa_pkg;

	// Field widths fixed by the payload words.
	localparam int SAMPLE_BITS  = 12;
	localparam int CHANNEL_BITS = 6;
	localparam int CFG_BITS     = 10;

	// Default width of the sample counter.
	localparam int COUNT_BITS_DEFAULT = 10;

	// Reset value of the samples-per-average register.
	localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(10);

	// Poll status codes.
	localparam logic [1:0] STATUS_REJECTED = 2'd0;
	localparam logic [1:0] STATUS_TAKEN    = 2'd1;
	localparam logic [1:0] STATUS_ADDED    = 2'd2;
	localparam logic [1:0] STATUS_DONE     = 2'd3;

	// One poll word.
	typedef struct packed {
		logic [CHANNEL_BITS-1:0] channel;
		logic                    converter_busy;
		logic [SAMPLE_BITS-1:0]  conversion_value;
	} poll_word_t;

	// One result word.
	typedef struct packed {
		logic [1:0]             poll_status;
		logic                   start_conversion;
		logic                   new_value;
		logic [SAMPLE_BITS-1:0] average;
	} result_word_t;

	// Divider status toward the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

[hdl/aosa_divider.sv]
// Iterative restoring divider for the averager, one quotient bit per cycle.
// Depends on aosa_pkg for the status struct.
module aosa_divider #(
	parameter int DIVIDEND_BITS = 22,
	parameter int DIVISOR_BITS  = 10
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [DIVIDEND_BITS-1:0] dividend,
	input  logic [DIVISOR_BITS-1:0]  divisor,
	output logic [DIVIDEND_BITS-1:0] quotient,
	output aosa_pkg::div_status_t    status
);

	localparam int STEP_W = (DIVIDEND_BITS > 1) ? $clog2(DIVIDEND_BITS) : 1;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_BITS - 1);

	logic                     busy_q;
	logic                     done_q;
	logic [STEP_W-1:0]        step_q;
	logic [DIVIDEND_BITS-1:0] quo_q;
	logic [DIVISOR_BITS-1:0]  rem_q;
	logic [DIVISOR_BITS-1:0]  dsr_q;
	logic [DIVISOR_BITS:0]    rem_shift;
	logic [DIVISOR_BITS:0]    trial;

	// Shift in the next dividend bit and try a subtraction.
	always_comb begin
		rem_shift = {rem_q, quo_q[DIVIDEND_BITS-1]};
		trial     = rem_shift - {1'b0, dsr_q};
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	// Remainder and quotient registers.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[DIVISOR_BITS]) begin
				rem_q <= trial[DIVISOR_BITS-1:0];
				quo_q <= {quo_q[DIVIDEND_BITS-2:0], 1'b1};
			end else begin
				rem_q <= rem_shift[DIVISOR_BITS-1:0];
				quo_q <= {quo_q[DIVIDEND_BITS-2:0], 1'b0};
			end
		end
	end

	assign quotient    = quo_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

	// A new division never starts on top of one in progress.
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");

	// Done follows the last step of an iteration.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a preceding step");

endmodule

[hdl/adc_owned_sample_averager_core.sv]
// ADC owned-sample averager: channel ownership, sample summing, average output.
// Rejected, taken and added polls give their result word through the write-back state.
// A completed average first passes through the bit-serial divider for sum / count;
// polls are accepted only while the sequencer is idle.
// A pending result sits in the output register while the next poll is taken.
// Asynchronous active-low reset frees the converter, clears the sum and count, sets
// samples_per_average to 10 and empties the output register.
module adc_owned_sample_averager_core #(
	parameter int COUNT_BITS = aosa_pkg::COUNT_BITS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                poll_valid,
	output logic                                poll_ready,
	input  aosa_pkg::poll_word_t                poll,
	output logic                                result_valid,
	input  logic                                result_ready,
	output aosa_pkg::result_word_t              result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [aosa_pkg::CFG_BITS-1:0]       cfg_data
);

	localparam int SUM_BITS = aosa_pkg::SAMPLE_BITS + COUNT_BITS;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_WB   = 3'b100
	} state_t;

	state_t                          state_q;
	logic [aosa_pkg::CFG_BITS-1:0]   spa_q;
	logic                            owner_valid_q;
	logic [aosa_pkg::CHANNEL_BITS-1:0] owner_channel_q;
	logic [SUM_BITS-1:0]             sample_sum_q;
	logic [COUNT_BITS-1:0]           sample_count_q;
	aosa_pkg::result_word_t          pend_q;
	aosa_pkg::result_word_t          result_q;
	logic                            result_valid_q;

	logic                            poll_acc;
	logic                            reject;
	logic [COUNT_BITS-1:0]           target;
	logic [SUM_BITS-1:0]             sum_next;
	logic [COUNT_BITS-1:0]           count_next;
	logic                            avg_done;
	logic                            div_start;
	logic [SUM_BITS-1:0]             div_quotient;
	aosa_pkg::div_status_t           div_status;
	logic                            wb_load;

	assign cfg_ready  = 1'b1;
	assign poll_ready = (state_q == ST_IDLE);
	assign poll_acc   = poll_valid && poll_ready;

	// Decode of the poll against the current ownership and count.
	always_comb begin
		target     = COUNT_BITS'(spa_q);
		reject     = poll.converter_busy ||
			(owner_valid_q && (owner_channel_q != poll.channel));
		sum_next   = sample_sum_q + SUM_BITS'(poll.conversion_value);
		count_next = (sample_count_q != COUNT_MAX) ? sample_count_q + 1'b1 : sample_count_q;
		avg_done   = (count_next >= target);
		div_start  = poll_acc && !reject && owner_valid_q && avg_done;
		wb_load    = (state_q == ST_WB) && (!result_valid_q || result_ready);
	end

	// Samples-per-average register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spa_q <= aosa_pkg::CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			spa_q <= cfg_data;
		end
	end

	// Sequencer and ownership state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			owner_valid_q   <= 1'b0;
			owner_channel_q <= '0;
			sample_sum_q    <= '0;
			sample_count_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (poll_acc) begin
						state_q <= div_start ? ST_DIV : ST_WB;
						if (!reject) begin
							if (!owner_valid_q) begin
								owner_valid_q   <= 1'b1;
								owner_channel_q <= poll.channel;
								sample_sum_q    <= '0;
								sample_count_q  <= '0;
							end else begin
								sample_sum_q   <= sum_next;
								sample_count_q <= count_next;
								if (avg_done) begin
									owner_valid_q <= 1'b0;
								end
							end
						end
					end
				end
				ST_DIV: begin
					if (div_status.done) begin
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					if (wb_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Pending result word, filled at acceptance and by the divider.
	always_ff @(posedge clk) begin
		if (poll_acc) begin
			pend_q.average <= '0;
			if (reject) begin
				pend_q.poll_status      <= aosa_pkg::STATUS_REJECTED;
				pend_q.start_conversion <= 1'b0;
				pend_q.new_value        <= 1'b0;
			end else if (!owner_valid_q) begin
				pend_q.poll_status      <= aosa_pkg::STATUS_TAKEN;
				pend_q.start_conversion <= 1'b1;
				pend_q.new_value        <= 1'b0;
			end else if (avg_done) begin
				pend_q.poll_status      <= aosa_pkg::STATUS_DONE;
				pend_q.start_conversion <= 1'b0;
				pend_q.new_value        <= 1'b1;
			end else begin
				pend_q.poll_status      <= aosa_pkg::STATUS_ADDED;
				pend_q.start_conversion <= 1'b1;
				pend_q.new_value        <= 1'b0;
			end
		end else if ((state_q == ST_DIV) && div_status.done) begin
			pend_q.average <= div_quotient[aosa_pkg::SAMPLE_BITS-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (wb_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wb_load) begin
			result_q <= pend_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Divider for sum / count.
	aosa_divider #(
		.DIVIDEND_BITS(SUM_BITS),
		.DIVISOR_BITS (COUNT_BITS)
	) u_divider (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(sum_next),
		.divisor (count_next),
		.quotient(div_quotient),
		.status  (div_status)
	);

	// The divider only reports completion while the sequencer waits for it.
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_status.done |-> (state_q == ST_DIV))
		else $error("divider done outside the divide state");

	// Ownership is released before the average is computed.
	a_free_during_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> !owner_valid_q)
		else $error("owner still valid while dividing");

	// A poll is never accepted while the divider is working.
	a_idle_divider: assert property (@(posedge clk) disable iff (!arst_n)
		poll_acc |-> !div_status.busy)
		else $error("poll accepted while divider busy");

	// A new result word only appears from the write-back state.
	a_result_from_wb: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == ST_WB))
		else $error("result word loaded outside write-back");

endmodule

[test/tb_adc_owned_sample_averager_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for adc_owned_sample_averager_core.
// Depends on aosa_pkg and the core; predicts every result word from its own model.
module tb_adc_owned_sample_averager_core;

	localparam int SAMPLE_BITS  = aosa_pkg::SAMPLE_BITS;
	localparam int CHANNEL_BITS = aosa_pkg::CHANNEL_BITS;
	localparam int CFG_BITS     = aosa_pkg::CFG_BITS;
	localparam int COUNT_BITS   = aosa_pkg::COUNT_BITS_DEFAULT;
	localparam int SUM_BITS     = SAMPLE_BITS + COUNT_BITS;
	localparam int DRAIN_CYCLES = 40;
	localparam int LONG_HOLD    = 400;
	localparam int CYCLE_LIMIT  = 1000000;

	typedef aosa_pkg::poll_word_t   poll_word_t;
	typedef aosa_pkg::result_word_t result_word_t;

	// How the owner's conversion values are chosen within one measurement.
	typedef enum int {
		VALUES_ANY,
		VALUES_RANDOM,
		VALUES_FULL_SCALE,
		VALUES_ZERO,
		VALUES_EXTREMES
	} value_style_t;

	// Tracks converter ownership and the running sum, and queues the expected words.
	class averager_scoreboard;
		bit                      owner_valid;
		logic [CHANNEL_BITS-1:0] owner_channel;
		logic [SUM_BITS-1:0]     sample_sum;
		logic [COUNT_BITS-1:0]   sample_count;
		logic [CFG_BITS-1:0]     samples_per_average;
		result_word_t            expected_q[$];
		int                      errors;
		int                      reported;

		function new();
			owner_valid = 1'b0;
			owner_channel = '0;
			sample_sum = '0;
			sample_count = '0;
			samples_per_average = aosa_pkg::CFG_RESET;
			errors = 0;
			reported = 0;
		endfunction

		function void set_samples_per_average(logic [CFG_BITS-1:0] value);
			samples_per_average = value;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Applies one accepted poll word to the ownership state.
		function void note_poll(poll_word_t p);
			result_word_t          r;
			logic [COUNT_BITS-1:0] target;
			r = '0;
			target = COUNT_BITS'(samples_per_average);
			if (p.converter_busy || (owner_valid && owner_channel != p.channel)) begin
				r.poll_status = aosa_pkg::STATUS_REJECTED;
			end else if (!owner_valid) begin
				owner_valid = 1'b1;
				owner_channel = p.channel;
				sample_sum = '0;
				sample_count = '0;
				r.poll_status = aosa_pkg::STATUS_TAKEN;
				r.start_conversion = 1'b1;
			end else begin
				sample_sum = sample_sum + SUM_BITS'(p.conversion_value);
				if (sample_count != '1)
					sample_count = sample_count + 1'b1;
				// A configured count of zero completes on the first sample.
				if (sample_count >= target) begin
					r.average = SAMPLE_BITS'(sample_sum / sample_count);
					r.new_value = 1'b1;
					r.poll_status = aosa_pkg::STATUS_DONE;
					owner_valid = 1'b0;
				end else begin
					r.poll_status = aosa_pkg::STATUS_ADDED;
					r.start_conversion = 1'b1;
				end
			end
			expected_q.push_back(r);
		endfunction

		// Compares one accepted result word with the oldest expectation.
		function void check_result(result_word_t got);
			result_word_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (reported < 10) begin
					reported++;
					$display("%0t: unexpected result word %h", $realtime, got);
				end
				return;
			end
			want = expected_q.pop_front();
			if (got.poll_status !== want.poll_status
					|| got.start_conversion !== want.start_conversion
					|| got.new_value !== want.new_value
					|| got.average !== want.average) begin
				errors++;
				if (reported < 10) begin
					reported++;
					$display("%0t: mismatch status %0d/%0d start %0b/%0b new %0b/%0b avg %0d/%0d",
						$realtime, got.poll_status, want.poll_status,
						got.start_conversion, want.start_conversion,
						got.new_value, want.new_value, got.average, want.average);
				end
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n = 1'b0;
	logic                poll_valid = 1'b0;
	logic                poll_ready;
	poll_word_t          poll = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	result_word_t        result;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CFG_BITS-1:0] cfg_data = '0;

	averager_scoreboard sb;
	bit                 quiet = 1'b0;
	bit                 rx_hold_request = 1'b0;
	int                 rx_stall_left = 0;
	int                 polls_sent = 0;
	int                 cycle_count = 0;

	adc_owned_sample_averager_core #(
		.COUNT_BITS(COUNT_BITS)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.poll_valid  (poll_valid),
		.poll_ready  (poll_ready),
		.poll        (poll),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit; a hang anywhere ends here.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	// Result side: check each accepted word, then pick the next ready level.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_result(result);
		if (rx_stall_left > 0) begin
			result_ready <= 1'b0;
			rx_stall_left--;
		end else if (rx_hold_request) begin
			// Long hold-off so that the core fills up and stalls its poll input.
			rx_hold_request = 1'b0;
			rx_stall_left = LONG_HOLD - 1;
			result_ready <= 1'b0;
		end else if (quiet) begin
			result_ready <= 1'b1;
		end else begin
			int r;
			r = $urandom_range(99);
			if (r < 70) begin
				result_ready <= 1'b1;
			end else begin
				result_ready <= 1'b0;
				rx_stall_left = (r < 95) ? $urandom_range(2) : $urandom_range(59, 9);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] pick_value(value_style_t style);
		case (style)
			VALUES_FULL_SCALE: return '1;
			VALUES_ZERO:       return '0;
			VALUES_EXTREMES:   return $urandom_range(1) ? '1 : '0;
			default:           return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	// Offers one poll word and holds it until accepted; valid stays high if no gap follows.
	task automatic send_poll(input logic [CHANNEL_BITS-1:0] chan, input logic busy,
			input logic [SAMPLE_BITS-1:0] value);
		poll_word_t w;
		int         gap;
		w.channel = chan;
		w.converter_busy = busy;
		w.conversion_value = value;
		poll <= w;
		poll_valid <= 1'b1;
		do @(posedge clk); while (!poll_ready);
		sb.note_poll(w);
		polls_sent++;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			poll_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops offering polls until every expected word has arrived.
	task automatic wait_drained();
		poll_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// Register write between phases, once the core has gone quiet.
	task automatic write_samples_per_average(input logic [CFG_BITS-1:0] value);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_samples_per_average(value);
	endtask

	// Finishes any open measurement by polling the owner until it releases.
	task automatic close_out();
		while (sb.owner_valid)
			send_poll(sb.owner_channel, 1'b0, pick_value(VALUES_RANDOM));
	endtask

	// One poll that must be rejected or ignored by the owner's sequence.
	task automatic send_noise(input logic [CHANNEL_BITS-1:0] chan);
		logic [CHANNEL_BITS-1:0] other;
		case ($urandom_range(2))
			0: send_poll(chan, 1'b1, pick_value(VALUES_RANDOM));
			1: begin
				other = chan ^ CHANNEL_BITS'($urandom_range(63, 1));
				send_poll(other, 1'($urandom), pick_value(VALUES_RANDOM));
			end
			default: send_poll(CHANNEL_BITS'($urandom), 1'b1, pick_value(VALUES_RANDOM));
		endcase
	endtask

	// A well-formed measurement: take ownership, then feed samples until the average.
	task automatic run_measurement(input logic [CHANNEL_BITS-1:0] chan, input value_style_t style,
			input int noise_pct);
		close_out();
		send_poll(chan, 1'b0, pick_value(VALUES_RANDOM));
		while (sb.owner_valid) begin
			if ($urandom_range(99) < noise_pct)
				send_noise(chan);
			send_poll(chan, 1'b0, pick_value(style));
		end
	endtask

	// Random measurements with short bursts of stray polls between them.
	task automatic run_items(input int count, input value_style_t style, input int noise_pct);
		int           start;
		int           junk;
		value_style_t s;
		start = polls_sent;
		while (polls_sent - start < count) begin
			junk = $urandom_range(3);
			repeat (junk)
				send_poll(CHANNEL_BITS'($urandom), 1'($urandom), pick_value(VALUES_RANDOM));
			s = style;
			if (s == VALUES_ANY)
				s = value_style_t'($urandom_range(VALUES_EXTREMES, VALUES_RANDOM));
			run_measurement(CHANNEL_BITS'($urandom), s, noise_pct);
		end
		close_out();
	endtask

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset count of ten.
		send_poll(6'd0, 1'b1, 12'hfff);
		send_poll(6'd0, 1'b0, 12'h000);
		send_poll(6'd63, 1'b0, 12'hfff);
		send_poll(6'd63, 1'b1, 12'h000);
		send_poll(6'd0, 1'b1, 12'hfff);
		repeat (9) send_poll(6'd0, 1'b0, 12'hfff);
		send_poll(6'd0, 1'b0, 12'h000);

		// Zero count acts like one; then a count of one.
		write_samples_per_average(10'd0);
		send_poll(6'd63, 1'b0, 12'h000);
		send_poll(6'd63, 1'b0, 12'hfff);
		send_poll(6'd42, 1'b0, 12'hfff);
		send_poll(6'd42, 1'b0, 12'h000);
		write_samples_per_average(10'd1);
		send_poll(6'd21, 1'b0, 12'h555);
		send_poll(6'd21, 1'b0, 12'haaa);

		// Random part over several counts.
		run_items(60, VALUES_ANY, 30);
		write_samples_per_average(10'd0);
		run_items(60, VALUES_ANY, 30);

		// Back-to-back polls while the result side holds off for a long stretch.
		write_samples_per_average(10'd2);
		quiet = 1'b1;
		rx_hold_request = 1'b1;
		run_items(80, VALUES_ANY, 20);
		quiet = 1'b0;

		// Sender pauses mid-phase until everything has come back.
		write_samples_per_average(10'd3);
		run_items(60, VALUES_ANY, 30);
		wait_drained();
		run_items(60, VALUES_ANY, 30);

		write_samples_per_average(CFG_BITS'($urandom_range(12, 4)));
		run_items(80, VALUES_ANY, 25);

		// Largest count with full-scale samples: the sum comes close to its top.
		write_samples_per_average('1);
		run_measurement(CHANNEL_BITS'($urandom), VALUES_FULL_SCALE, 5);

		write_samples_per_average(CFG_BITS'($urandom_range(40, 13)));
		quiet = 1'b1;
		run_items(120, VALUES_ANY, 15);
		quiet = 1'b0;
		write_samples_per_average(aosa_pkg::CFG_RESET);
		run_items(80, VALUES_ANY, 30);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
